@@ src/matrix_vector_multiply_core_assert.svh @@
// ----------------------------------------------------------------------------
// matrix_vector_multiply_core assertion macros
// Shared property forms for the checker of the matrix-vector core.
// ----------------------------------------------------------------------------
`ifndef MATRIX_VECTOR_MULTIPLY_CORE_ASSERT_SVH
`define MATRIX_VECTOR_MULTIPLY_CORE_ASSERT_SVH

// same-cycle implication, checked at every rising edge outside reset
`define MVM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked at every rising edge outside reset
`define MVM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/mvm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvm_pkg
// Field widths, command and register codes, and the Q16.16 saturation used
// by the matrix-vector core and its checker.
// ----------------------------------------------------------------------------
package mvm_pkg;

    // word field widths
    localparam int CMD_W   = 2;
    localparam int IDX_FW  = 4;
    localparam int VAL_W   = 32;
    localparam int SIZE_W  = 5;
    localparam int FRAC_W  = 16;

    // largest size the 4-bit index fields can address
    localparam int FIELD_SIZE = 1 << IDX_FW;

    // accumulator: 64-bit products, 16 terms, one sign guard
    localparam int ACC_W = 68;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = SIZE_W;

    localparam logic [CFG_ADDR_W-1:0] REG_MATRIX_SIZE   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_VECTOR_LENGTH = 2'd1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

    // command codes, code 3 is unused
    localparam logic [CMD_W-1:0] CMD_LOAD_MATRIX = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_VECTOR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPUTE     = 2'd2;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_MISMATCH = 1'b1;

    localparam logic [VAL_W-1:0] VAL_MAX = 32'h7fff_ffff;
    localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;

    // floor shift by the fraction width, then clamp to 32-bit signed
    function automatic logic [VAL_W-1:0] sat_q16(input logic [ACC_W-1:0] acc);
        logic [ACC_W-FRAC_W-VAL_W:0] top;
        logic [VAL_W-1:0]            res;
        top = acc[ACC_W-1:FRAC_W+VAL_W-1];
        if (top == '0 || top == '1) begin
            res = acc[FRAC_W+VAL_W-1:FRAC_W];
        end else if (acc[ACC_W-1]) begin
            res = VAL_MIN;
        end else begin
            res = VAL_MAX;
        end
        return res;
    endfunction

endpackage

@@ src/mvm_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvm channel interfaces
// Valid/ready channels for command words, result words and register writes.
// ----------------------------------------------------------------------------

// command word channel
interface mvm_in_if import mvm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [IDX_FW-1:0] row;
    logic [IDX_FW-1:0] col;
    logic [VAL_W-1:0]  value;

    modport source (output valid, command, row, col, value, input ready);
    modport sink   (input valid, command, row, col, value, output ready);
endinterface

// result word channel
interface mvm_out_if import mvm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [IDX_FW-1:0] index;
    logic [VAL_W-1:0]  result_value;
    logic              last;
    logic              status;

    modport source (output valid, index, result_value, last, status, input ready);
    modport sink   (input valid, index, result_value, last, status, output ready);
endinterface

// register write channel
interface mvm_cfg_if import mvm_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

@@ src/matrix_vector_multiply_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_vector_multiply_core
// Square matrix times vector in Q16.16 with a bit-serial multiplier. Results
// overwrite the vector store and leave as words with a last marker.
// ----------------------------------------------------------------------------
//  channel  dir  handshake           payload
//  i_cfg    in   valid/ready         addr, data
//  i_in     in   valid/ready         command, row, col, value
//  o_out    out  valid/ready         index, result_value, last, status
//
//  loads are written into the stores when taken. a compute of size n runs a start state, then
//  per product a read state, a load state and the shift-add states of the bit-serial multiplier,
//  then a saturation state per row, then a read and a load state per emitted word.
//  a size mismatch emits one status word from the start state instead.
//  i_in.ready is low during a compute; output stalls hold the emit sequence.
//  reset is synchronous and clears control state only; stores start unknown.
// ----------------------------------------------------------------------------
module matrix_vector_multiply_core import mvm_pkg::*; #(
    parameter int MAX_SIZE = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mvm_cfg_if.sink    i_cfg,
    mvm_in_if.sink     i_in,
    mvm_out_if.source  o_out
);

    localparam int IDX_W     = $clog2(MAX_SIZE);
    localparam int CMP_W     = (IDX_W > SIZE_W) ? IDX_W : SIZE_W;
    localparam int SIZE_CAP  = (MAX_SIZE < FIELD_SIZE) ? MAX_SIZE : FIELD_SIZE;
    localparam int MAT_DEPTH = 1 << (2 * IDX_W);
    localparam int BIT_W     = $clog2(VAL_W);
    localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(VAL_W - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_RD,
        S_LD,
        S_MUL,
        S_ROW_END,
        S_EMIT_RD,
        S_EMIT_LD
    } t_state;

    t_state              r_state, n_state;
    logic [SIZE_W-1:0]   r_size, n_size;
    logic [SIZE_W-1:0]   r_vlen, n_vlen;
    logic [SIZE_W-1:0]   r_last_idx, n_last_idx;
    logic [IDX_W-1:0]    r_row, n_row;
    logic [IDX_W-1:0]    r_col, n_col;
    logic [BIT_W-1:0]    r_bit, n_bit;
    logic [ACC_W-1:0]    r_acc, n_acc;
    logic [ACC_W-1:0]    r_mcand, n_mcand;
    logic [VAL_W-1:0]    r_mplier, n_mplier;
    logic                r_o_valid, n_o_valid;
    logic [IDX_FW-1:0]   r_o_index, n_o_index;
    logic [VAL_W-1:0]    r_o_value, n_o_value;
    logic                r_o_last, n_o_last;
    logic                r_o_status, n_o_status;

    logic                w_in_acc;
    logic                w_out_free;
    logic [SIZE_W-1:0]   w_eff_size;
    logic [SIZE_W-1:0]   w_eff_vlen;
    logic [CMP_W-1:0]    w_row_cmp;
    logic [CMP_W-1:0]    w_col_cmp;
    logic [CMP_W-1:0]    w_last_cmp;
    logic [CMP_W-1:0]    w_in_row;
    logic [CMP_W-1:0]    w_in_col;
    logic                w_row_ok;
    logic                w_col_ok;

    logic                w_mat_we;
    logic [VAL_W-1:0]    w_mat_rdata;
    logic                w_vec_we;
    logic [IDX_W-1:0]    w_vec_waddr;
    logic [VAL_W-1:0]    w_vec_wdata;
    logic [VAL_W-1:0]    w_vec_rdata;
    logic                w_res_we;
    logic [VAL_W-1:0]    w_res_wdata;
    logic [VAL_W-1:0]    w_res_rdata;

    // handshakes
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in.valid && (r_state == S_IDLE);
    assign w_out_free  = !r_o_valid || o_out.ready;

    // effective sizes, clamped to the usable range
    assign w_eff_size = (r_size == '0) ? SIZE_W'(1) :
                        (r_size > SIZE_W'(SIZE_CAP)) ? SIZE_W'(SIZE_CAP) : r_size;
    assign w_eff_vlen = (r_vlen == '0) ? SIZE_W'(1) :
                        (r_vlen > SIZE_W'(SIZE_CAP)) ? SIZE_W'(SIZE_CAP) : r_vlen;

    // index compares at a common width
    assign w_row_cmp  = CMP_W'(r_row);
    assign w_col_cmp  = CMP_W'(r_col);
    assign w_last_cmp = CMP_W'(r_last_idx);
    assign w_in_row   = CMP_W'(i_in.row);
    assign w_in_col   = CMP_W'(i_in.col);
    assign w_row_ok   = 32'(i_in.row) < MAX_SIZE;
    assign w_col_ok   = 32'(i_in.col) < MAX_SIZE;

    // store write ports
    assign w_mat_we    = w_in_acc && (i_in.command == CMD_LOAD_MATRIX) && w_row_ok && w_col_ok;
    assign w_vec_we    = (w_in_acc && (i_in.command == CMD_LOAD_VECTOR) && w_row_ok) ||
                         ((r_state == S_EMIT_LD) && w_out_free);
    assign w_vec_waddr = (r_state == S_EMIT_LD) ? r_row : w_in_row[IDX_W-1:0];
    assign w_vec_wdata = (r_state == S_EMIT_LD) ? w_res_rdata : i_in.value;
    assign w_res_we    = (r_state == S_ROW_END);
    assign w_res_wdata = sat_q16(r_acc);

    // matrix store, addressed {row, col}
    mvm_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAT_DEPTH)
    ) u_mat_ram (
        .i_clk   (i_clk),
        .i_we    (w_mat_we),
        .i_waddr ({w_in_row[IDX_W-1:0], w_in_col[IDX_W-1:0]}),
        .i_wdata (i_in.value),
        .i_raddr ({r_row, r_col}),
        .o_rdata (w_mat_rdata)
    );

    // vector store, overwritten by results during the emit pass
    mvm_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_SIZE)
    ) u_vec_ram (
        .i_clk   (i_clk),
        .i_we    (w_vec_we),
        .i_waddr (w_vec_waddr),
        .i_wdata (w_vec_wdata),
        .i_raddr (r_col),
        .o_rdata (w_vec_rdata)
    );

    // row results held until every row has used the old vector
    mvm_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_SIZE)
    ) u_res_ram (
        .i_clk   (i_clk),
        .i_we    (w_res_we),
        .i_waddr (r_row),
        .i_wdata (w_res_wdata),
        .i_raddr (r_row),
        .o_rdata (w_res_rdata)
    );

    // sequencer next state
    always_comb begin
        n_state    = r_state;
        n_size     = r_size;
        n_vlen     = r_vlen;
        n_last_idx = r_last_idx;
        n_row      = r_row;
        n_col      = r_col;
        n_bit      = r_bit;
        n_acc      = r_acc;
        n_mcand    = r_mcand;
        n_mplier   = r_mplier;
        n_o_valid  = r_o_valid;
        n_o_index  = r_o_index;
        n_o_value  = r_o_value;
        n_o_last   = r_o_last;
        n_o_status = r_o_status;

        // register writes
        if (i_cfg.valid) begin
            unique case (i_cfg.addr)
                REG_MATRIX_SIZE:   n_size = i_cfg.data;
                REG_VECTOR_LENGTH: n_vlen = i_cfg.data;
                default: ;
            endcase
        end

        // output word taken
        if (r_o_valid && o_out.ready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && (i_in.command == CMD_COMPUTE)) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                if (w_eff_size != w_eff_vlen) begin
                    if (w_out_free) begin
                        n_o_valid  = 1'b1;
                        n_o_index  = '0;
                        n_o_value  = '0;
                        n_o_last   = 1'b1;
                        n_o_status = STATUS_MISMATCH;
                        n_state    = S_IDLE;
                    end
                end else begin
                    n_last_idx = w_eff_size - SIZE_W'(1);
                    n_row      = '0;
                    n_col      = '0;
                    n_acc      = '0;
                    n_state    = S_RD;
                end
            end
            S_RD: begin
                n_state = S_LD;
            end
            S_LD: begin
                n_mcand  = {{(ACC_W-VAL_W){w_mat_rdata[VAL_W-1]}}, w_mat_rdata};
                n_mplier = w_vec_rdata;
                n_bit    = '0;
                n_state  = S_MUL;
            end
            S_MUL: begin
                // one multiplier bit per cycle, the sign bit weighs negative
                if (r_mplier[0]) begin
                    n_acc = (r_bit == BIT_LAST) ? r_acc - r_mcand : r_acc + r_mcand;
                end
                n_mcand  = {r_mcand[ACC_W-2:0], 1'b0};
                n_mplier = {1'b0, r_mplier[VAL_W-1:1]};
                n_bit    = r_bit + BIT_W'(1);
                if (r_bit == BIT_LAST) begin
                    if (w_col_cmp == w_last_cmp) begin
                        n_state = S_ROW_END;
                    end else begin
                        n_col   = r_col + IDX_W'(1);
                        n_state = S_RD;
                    end
                end
            end
            S_ROW_END: begin
                n_col = '0;
                n_acc = '0;
                if (w_row_cmp == w_last_cmp) begin
                    n_row   = '0;
                    n_state = S_EMIT_RD;
                end else begin
                    n_row   = r_row + IDX_W'(1);
                    n_state = S_RD;
                end
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                if (w_out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_index  = w_row_cmp[IDX_FW-1:0];
                    n_o_value  = w_res_rdata;
                    n_o_last   = (w_row_cmp == w_last_cmp);
                    n_o_status = STATUS_OK;
                    if (w_row_cmp == w_last_cmp) begin
                        n_state = S_IDLE;
                    end else begin
                        n_row   = r_row + IDX_W'(1);
                        n_state = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_size    <= SIZE_RESET;
            r_vlen    <= SIZE_RESET;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_size    <= n_size;
            r_vlen    <= n_vlen;
            r_o_valid <= n_o_valid;
        end
        r_last_idx <= n_last_idx;
        r_row      <= n_row;
        r_col      <= n_col;
        r_bit      <= n_bit;
        r_acc      <= n_acc;
        r_mcand    <= n_mcand;
        r_mplier   <= n_mplier;
        r_o_index  <= n_o_index;
        r_o_value  <= n_o_value;
        r_o_last   <= n_o_last;
        r_o_status <= n_o_status;
    end

    // result word
    assign o_out.valid        = r_o_valid;
    assign o_out.index        = r_o_index;
    assign o_out.result_value = r_o_value;
    assign o_out.last         = r_o_last;
    assign o_out.status       = r_o_status;

endmodule

@@ src/mvm_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvm_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mvm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/mvm_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvm_checker
// Port-level checks on the matrix-vector core, bound to the top level.
// ----------------------------------------------------------------------------
`include "matrix_vector_multiply_core_assert.svh"

module mvm_checker import mvm_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic [CMD_W-1:0]  i_in_command,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [IDX_FW-1:0] i_out_index,
    input logic [VAL_W-1:0]  i_out_value,
    input logic              i_out_last,
    input logic              i_out_status
);

    // a stalled result word holds
    `MVM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_index) && $stable(i_out_value) && $stable(i_out_last) && $stable(i_out_status), "result word changed while stalled")

    // a mismatch status word is a lone word with zero index and value
    `MVM_ASSERT_SAME(a_err_word, i_clk, i_rst_n, i_out_valid && (i_out_status == STATUS_MISMATCH), i_out_last && (i_out_index == '0) && (i_out_value == '0), "malformed status word")

    // a compute closes the command channel on the next cycle
    `MVM_ASSERT_NEXT(a_compute_busy, i_clk, i_rst_n, i_in_valid && i_in_ready && (i_in_command == CMD_COMPUTE), !i_in_ready, "command accepted right after compute")

    // no command is taken while a compute still has words to emit
    `MVM_ASSERT_SAME(a_emit_busy, i_clk, i_rst_n, i_out_valid && !i_out_last, !i_in_ready, "command channel open mid-result")

endmodule

bind matrix_vector_multiply_core mvm_checker u_mvm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_command (i_in.command),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_index  (o_out.index),
    .i_out_value  (o_out.result_value),
    .i_out_last   (o_out.last),
    .i_out_status (o_out.status)
);

@@ bench/tb_matrix_vector_multiply_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix_vector_multiply_core
// Self-checking bench for the Q16.16 matrix-vector core. Command words are
// fed through the input channel and the register port. A scoreboard keeps
// its own copy of the stores and the sizes and predicts every result word.
// It starts with a directed set of words: saturation at both ends, the floor
// rounding of negative sums, the unused command, the size mismatch and the
// clamping of register codes. Random phases follow, each with fresh sizes
// and the idling pattern changing along the run. Every product only reads
// store entries that were loaded before.
// ----------------------------------------------------------------------------
module tb_matrix_vector_multiply_core;
    import mvm_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 6;
    localparam int RANDOM_WORDS  = 420;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_SIZE     = 4;
    localparam int HOLD_CYCLES   = 2000;
    localparam int CYCLE_LIMIT   = 1_500_000;

    // codes the block ignores
    localparam logic [CMD_W-1:0]      CMD_UNUSED   = 2'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_A = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_B = 2'd3;

    typedef struct packed {
        logic [IDX_FW-1:0] index;
        logic [VAL_W-1:0]  result_value;
        logic              last;
        logic              status;
    } t_result;

    // store copies, size registers and the queue of predicted result words
    class product_scoreboard;
        logic [VAL_W-1:0]  mat_copy [FIELD_SIZE*FIELD_SIZE];
        logic [VAL_W-1:0]  vec_copy [FIELD_SIZE];
        logic [SIZE_W-1:0] size_reg;
        logic [SIZE_W-1:0] len_reg;
        t_result           pending_products [$];
        int                errors;
        int                checked;
        int                computes;
        int                mismatches;
        int                largest;

        function new();
            foreach (mat_copy[k]) mat_copy[k] = '0;
            foreach (vec_copy[k]) vec_copy[k] = '0;
            size_reg   = SIZE_RESET;
            len_reg    = SIZE_RESET;
            errors     = 0;
            checked    = 0;
            computes   = 0;
            mismatches = 0;
            largest    = 0;
        endfunction

        // register code clamped to the sizes the index fields reach
        static function int eff_size(input logic [SIZE_W-1:0] code);
            if (code == '0) return 1;
            if (code > FIELD_SIZE) return FIELD_SIZE;
            return int'(code);
        endfunction

        function void set_register(input logic [CFG_ADDR_W-1:0] addr,
                                   input logic [SIZE_W-1:0] data);
            if (addr == REG_MATRIX_SIZE) size_reg = data;
            else if (addr == REG_VECTOR_LENGTH) len_reg = data;
        endfunction

        function int pending_count();
            return pending_products.size();
        endfunction

        // row sums of exact products, floored by the fraction, then clamped
        function void predict_products();
            int                       n;
            int                       i;
            int                       j;
            logic signed [63:0]       prod;
            logic signed [ACC_W-1:0]  acc;
            logic signed [ACC_W-1:0]  shifted;
            logic [VAL_W-1:0]         row_res [FIELD_SIZE];
            t_result                  r;
            n = eff_size(size_reg);
            computes++;
            if (eff_size(len_reg) != n) begin
                r.index        = '0;
                r.result_value = '0;
                r.last         = 1'b1;
                r.status       = STATUS_MISMATCH;
                pending_products.push_back(r);
                mismatches++;
                return;
            end
            if (n > largest) largest = n;
            for (i = 0; i < n; i++) begin
                acc = '0;
                for (j = 0; j < n; j++) begin
                    prod = $signed(mat_copy[i*FIELD_SIZE + j]) * $signed(vec_copy[j]);
                    acc  = acc + prod;
                end
                shifted = acc >>> FRAC_W;
                if (shifted > $signed({{(ACC_W-VAL_W){1'b0}}, VAL_MAX})) begin
                    row_res[i] = VAL_MAX;
                end else if (shifted < $signed({{(ACC_W-VAL_W){1'b1}}, VAL_MIN})) begin
                    row_res[i] = VAL_MIN;
                end else begin
                    row_res[i] = shifted[VAL_W-1:0];
                end
            end
            // results overwrite the vector in place
            for (i = 0; i < n; i++) begin
                vec_copy[i]    = row_res[i];
                r.index        = i[IDX_FW-1:0];
                r.result_value = row_res[i];
                r.last         = (i == n - 1);
                r.status       = STATUS_OK;
                pending_products.push_back(r);
            end
        endfunction

        // called for every accepted command word
        function void note_word(input logic [CMD_W-1:0] cmd, input logic [IDX_FW-1:0] row,
                                input logic [IDX_FW-1:0] col, input logic [VAL_W-1:0] val);
            case (cmd)
                CMD_LOAD_MATRIX: mat_copy[int'(row)*FIELD_SIZE + int'(col)] = val;
                CMD_LOAD_VECTOR: vec_copy[int'(row)] = val;
                CMD_COMPUTE:     predict_products();
                default: ;
            endcase
        endfunction

        // called for every accepted result word
        function void check_word(input t_result got);
            t_result want;
            checked++;
            if (pending_products.size() == 0) begin
                $error("result word with nothing expected: index %0d value %h",
                       got.index, got.result_value);
                errors++;
                return;
            end
            want = pending_products.pop_front();
            if (got.index !== want.index) begin
                $error("index: expected %0d, got %0d", want.index, got.index);
                errors++;
            end
            if (got.result_value !== want.result_value) begin
                $error("result_value: expected %h, got %h", want.result_value,
                       got.result_value);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0b, got %0b", want.last, got.last);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0b, got %0b", want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    mvm_in_if  in_if ();
    mvm_out_if out_if ();
    mvm_cfg_if cfg_if ();

    matrix_vector_multiply_core #(
        .MAX_SIZE (FIELD_SIZE)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    product_scoreboard sb = new();

    // entries loaded so far, so that no compute reads an unwritten one
    bit mat_written [FIELD_SIZE*FIELD_SIZE];
    bit vec_written [FIELD_SIZE];

    int send_idle_pct = 37;
    int recv_idle_pct = 50;
    int hold_request  = 0;
    int random_words  = 0;
    int cycle_count;

    // clock
    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    // run limit
    initial begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) begin
            @(posedge i_clk);
        end
        $display("FAIL");
        $finish;
    end

    // result receiver: random stalls, or one long hold when asked
    initial begin : result_receiver
        int hold_len;
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold_len     = hold_request;
                hold_request = 0;
                out_if.ready <= 1'b0;
                repeat (hold_len) @(posedge i_clk);
            end else begin
                out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // result word monitor
    always @(posedge i_clk) begin : result_monitor
        t_result got;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            got.index        = out_if.index;
            got.result_value = out_if.result_value;
            got.last         = out_if.last;
            got.status       = out_if.status;
            sb.check_word(got);
        end
    end

    // value mix: small magnitudes, full range, extremes
    function automatic logic [VAL_W-1:0] rand_value();
        logic [VAL_W-1:0] v;
        int               pick;
        pick = $urandom_range(9);
        v    = $urandom;
        if (pick < 4) begin
            v = {{(VAL_W-20){v[19]}}, v[19:0]};
        end else if (pick >= 8) begin
            case ($urandom_range(3))
                0:       v = VAL_MAX;
                1:       v = VAL_MIN;
                2:       v = '0;
                default: v = '1;
            endcase
        end
        return v;
    endfunction

    // register code for a size, using the clamped codes now and then
    function automatic logic [SIZE_W-1:0] size_code(input int n);
        if (n == 1 && $urandom_range(1) == 0) return '0;
        if (n == FIELD_SIZE) return SIZE_W'($urandom_range(FIELD_SIZE, (1 << SIZE_W) - 1));
        return SIZE_W'(n);
    endfunction

    // one register write, valid left high for a following write
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [SIZE_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.addr  <= addr;
        cfg_if.data  <= data;
        @(posedge i_clk);
        while (cfg_if.ready !== 1'b1) @(posedge i_clk);
        sb.set_register(addr, data);
    endtask

    // one command word with random idle cycles ahead of it
    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [IDX_FW-1:0] row,
                             input logic [IDX_FW-1:0] col, input logic [VAL_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.command <= cmd;
        in_if.row     <= row;
        in_if.col     <= col;
        in_if.value   <= val;
        @(posedge i_clk);
        while (in_if.ready !== 1'b1) @(posedge i_clk);
        sb.note_word(cmd, row, col, val);
        if (cmd == CMD_LOAD_MATRIX) mat_written[int'(row)*FIELD_SIZE + int'(col)] = 1'b1;
        if (cmd == CMD_LOAD_VECTOR) vec_written[int'(row)] = 1'b1;
        if (cmd != CMD_UNUSED) random_words++;
    endtask

    // stop offering and wait until every predicted word has come
    task automatic drain();
        in_if.valid <= 1'b0;
        while (sb.pending_count() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_sizes(input logic [SIZE_W-1:0] ms, input logic [SIZE_W-1:0] vl);
        drain();
        write_reg(REG_MATRIX_SIZE, ms);
        write_reg(REG_VECTOR_LENGTH, vl);
        cfg_if.valid <= 1'b0;
    endtask

    // load whatever a compute of size n still lacks, then compute
    task automatic fill_and_compute(input int n);
        int i;
        int j;
        for (i = 0; i < n; i++) begin
            for (j = 0; j < n; j++) begin
                if (!mat_written[i*FIELD_SIZE + j]) begin
                    send_word(CMD_LOAD_MATRIX, IDX_FW'(i), IDX_FW'(j), rand_value());
                end
            end
        end
        for (j = 0; j < n; j++) begin
            if (!vec_written[j]) begin
                send_word(CMD_LOAD_VECTOR, IDX_FW'(j), IDX_FW'($urandom), rand_value());
            end
        end
        send_word(CMD_COMPUTE, IDX_FW'($urandom), IDX_FW'($urandom), VAL_W'($urandom));
    endtask

    // loads mostly inside the active size, some anywhere, some unused words
    task automatic random_loads(input int n, input int count);
        int               k;
        int               kind;
        logic [CMD_W-1:0] cmd;
        for (k = 0; k < count; k++) begin
            kind = $urandom_range(9);
            if (kind < 6) begin
                send_word(CMD_LOAD_MATRIX, IDX_FW'($urandom_range(n - 1)),
                          IDX_FW'($urandom_range(n - 1)), rand_value());
            end else if (kind < 8) begin
                send_word(CMD_LOAD_VECTOR, IDX_FW'($urandom_range(n - 1)),
                          IDX_FW'($urandom), rand_value());
            end else if (kind == 8) begin
                cmd = ($urandom_range(1) == 0) ? CMD_LOAD_MATRIX : CMD_LOAD_VECTOR;
                send_word(cmd, IDX_FW'($urandom), IDX_FW'($urandom), rand_value());
            end else begin
                send_word(CMD_UNUSED, IDX_FW'($urandom), IDX_FW'($urandom), VAL_W'($urandom));
            end
        end
    endtask

    // main sequence
    initial begin : stimulus
        int               phase;
        int               n;
        int               pick;
        int               runs;
        int               k;
        bit               matched;
        logic [SIZE_W-1:0] ms;
        logic [SIZE_W-1:0] vl;

        i_rst_n       = 1'b0;
        in_if.valid   = 1'b0;
        in_if.command = CMD_LOAD_MATRIX;
        in_if.row     = '0;
        in_if.col     = '0;
        in_if.value   = '0;
        cfg_if.valid  = 1'b0;
        cfg_if.addr   = REG_MATRIX_SIZE;
        cfg_if.data   = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: one by one, saturation at both ends and floor rounding
        set_sizes(5'd1, 5'd1);
        send_word(CMD_LOAD_MATRIX, '0, '0, VAL_MAX);
        send_word(CMD_LOAD_VECTOR, '0, '0, VAL_MAX);
        send_word(CMD_COMPUTE, '0, '0, '0);
        send_word(CMD_LOAD_MATRIX, '0, '0, VAL_MIN);
        send_word(CMD_LOAD_VECTOR, '0, '1, VAL_MAX);
        send_word(CMD_COMPUTE, '1, '1, '1);
        send_word(CMD_LOAD_VECTOR, '0, '0, VAL_MIN);
        send_word(CMD_COMPUTE, '0, '0, '0);
        send_word(CMD_LOAD_MATRIX, '0, '0, '1);
        send_word(CMD_LOAD_VECTOR, '0, '0, 32'h0000_0001);
        send_word(CMD_COMPUTE, '0, '0, '0);
        // unused command and loads outside the active size
        send_word(CMD_UNUSED, '1, '1, '1);
        send_word(CMD_LOAD_MATRIX, '1, '1, '0);
        send_word(CMD_LOAD_VECTOR, '1, '0, '1);
        send_word(CMD_COMPUTE, '0, '0, '0);

        // directed: size mismatch, clamped codes, ignored register indexes
        set_sizes(5'd1, 5'd2);
        send_word(CMD_COMPUTE, '0, '0, '0);
        set_sizes(5'd0, 5'd31);
        @(posedge i_clk);
        write_reg(REG_UNUSED_A, 5'd31);
        write_reg(REG_UNUSED_B, 5'd0);
        cfg_if.valid <= 1'b0;
        send_word(CMD_COMPUTE, '0, '0, '0);
        set_sizes(5'd0, 5'd1);
        send_word(CMD_COMPUTE, '0, '0, '0);

        // random phases, each with its own sizes
        random_words = 0;
        phase        = 0;
        while (random_words < RANDOM_WORDS) begin
            if (random_words < RANDOM_WORDS / 3) begin
                send_idle_pct = 37;
                recv_idle_pct = 50;
            end else if (random_words < 2 * RANDOM_WORDS / 3) begin
                send_idle_pct = 50;
                recv_idle_pct = 37;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            pick = $urandom_range(9);
            if (phase == 3 || phase == 11) begin
                n  = FIELD_SIZE;
                ms = size_code(n);
                vl = size_code(n);
            end else if (phase == 2) begin
                n  = HOLD_SIZE;
                ms = size_code(n);
                vl = size_code(n);
            end else if (pick < 9) begin
                if (pick < 6) n = $urandom_range(1, 4);
                else if (pick < 8) n = $urandom_range(5, 8);
                else n = $urandom_range(9, FIELD_SIZE - 1);
                ms = size_code(n);
                vl = size_code(n);
            end else begin
                do begin
                    ms = SIZE_W'($urandom);
                    vl = SIZE_W'($urandom);
                end while (product_scoreboard::eff_size(ms) ==
                           product_scoreboard::eff_size(vl));
            end
            n       = product_scoreboard::eff_size(ms);
            matched = (n == product_scoreboard::eff_size(vl));
            set_sizes(ms, vl);

            runs = (phase == 2) ? 3 : $urandom_range(1, 3);
            for (k = 0; k < runs; k++) begin
                random_loads(n, $urandom_range(0, 12));
                if (matched) begin
                    fill_and_compute(n);
                end else begin
                    send_word(CMD_COMPUTE, IDX_FW'($urandom), IDX_FW'($urandom),
                              VAL_W'($urandom));
                end
                // long output hold over the compute while words keep coming
                if (phase == 2 && k == 0) hold_request = HOLD_CYCLES;
            end
            phase++;
        end

        drain();
        $display("covered %0d computes (%0d size mismatches), largest size %0d",
                 sb.computes, sb.mismatches, sb.largest);
        $display("checked %0d result words over %0d random phases", sb.checked, phase);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
